@@ design/dbs_pkg.sv @@
// Shared types and constants for the diphoton plus b-jet pair event selector.
package dbs_pkg;

   localparam int MAX_OBJECTS = 32;
   localparam int IDX_W       = $clog2(MAX_OBJECTS);
   localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

   localparam logic [2:0] CMD_JET      = 3'd0;
   localparam logic [2:0] CMD_MUON     = 3'd1;
   localparam logic [2:0] CMD_ELECTRON = 3'd2;
   localparam logic [2:0] CMD_PHOTON   = 3'd3;

   localparam logic [1:0] KIND_JET    = 2'd0;
   localparam logic [1:0] KIND_BJET   = 2'd1;
   localparam logic [1:0] KIND_PHOTON = 2'd2;

   localparam logic [2:0] CSR_JET_PT_MIN    = 3'd0;
   localparam logic [2:0] CSR_PHOTON_PT_MIN = 3'd1;
   localparam logic [2:0] CSR_LEPTON_PT_MIN = 3'd2;
   localparam logic [2:0] CSR_ETA_MAX       = 3'd3;
   localparam logic [2:0] CSR_BB_MASS_LOW   = 3'd4;
   localparam logic [2:0] CSR_BB_MASS_HIGH  = 3'd5;
   localparam logic [2:0] CSR_GG_MASS_LOW   = 3'd6;
   localparam logic [2:0] CSR_GG_MASS_HIGH  = 3'd7;

   localparam logic [3:0] STAGE_PASS     = 4'd0;
   localparam logic [3:0] STAGE_BJETS    = 4'd1;
   localparam logic [3:0] STAGE_W_VETO   = 4'd2;
   localparam logic [3:0] STAGE_BB_DR    = 4'd3;
   localparam logic [3:0] STAGE_BB_MASS  = 4'd4;
   localparam logic [3:0] STAGE_LEPTON   = 4'd5;
   localparam logic [3:0] STAGE_PHOTONS  = 4'd6;
   localparam logic [3:0] STAGE_GG_MASS  = 4'd7;
   localparam logic [3:0] STAGE_GG_DR    = 4'd8;
   localparam logic [3:0] STAGE_ISO      = 4'd9;

   // W window (70, 90) GeV squared in 1/256 GeV^2
   localparam logic [34:0] W_MASS_LO_SQ = 35'd1254400;
   localparam logic [34:0] W_MASS_HI_SQ = 35'd2073600;
   // 25*dR^2 < 4*1024^2 means dR < 0.4
   localparam logic [34:0] DR_LIMIT     = 35'd4194304;

   typedef struct packed {
      logic [15:0]        energy;
      logic signed [16:0] mom_x;
      logic signed [16:0] mom_y;
      logic signed [16:0] mom_z;
      logic [15:0]        pt;
      logic signed [13:0] eta;
      logic signed [12:0] phi;
      logic [1:0]         kind;
   } obj_type;

   localparam int OBJ_W = $bits(obj_type);

   typedef struct packed {
      logic    store;
      logic    lepton;
      logic    last;
      obj_type obj;
   } item_type;

   typedef struct packed {
      logic [15:0] jet_pt_min;
      logic [15:0] photon_pt_min;
      logic [15:0] lepton_pt_min;
      logic [12:0] eta_max;
      logic [15:0] bb_mass_low;
      logic [15:0] bb_mass_high;
      logic [15:0] gg_mass_low;
      logic [15:0] gg_mass_high;
   } cfg_type;

endpackage

@@ design/diphoton_bb_event_selector_top.sv @@
// Top level of the diphoton plus b-jet pair event selector.
//
// Input channel (req_*): one object per transaction, accepted when req_push is
// high and req_full is low. The item with req_last_of_event closes the event.
// Result channel (rsp_*): one result per event, shown while rsp_empty is low,
// taken when rsp_pop is high. Config (csr_*): one-cycle write, no read-back.
// Objects enter a four-deep queue at one per cycle while it is not full; the
// back end pops one per cycle while idle and writes the stored ones into the
// object RAM. At event end the back end scans the store, runs the W veto over
// all object pairs (jet-jet pairs go through the mass pipeline), then up to 6
// further pair checks. The W pair scan sets most of the event latency.
// Objects of the next event keep entering while a result waits; the back
// end holds at event end until the result register is free.
// Reset clears the queue, the event state and the result valid flag, and loads
// the register defaults; the object store needs no clearing.
module diphoton_bb_event_selector_top import dbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_command,
   input  logic [15:0]        req_trans_momentum,
   input  logic signed [13:0] req_pseudorapidity,
   input  logic signed [12:0] req_azimuth,
   input  logic [15:0]        req_energy,
   input  logic signed [16:0] req_mom_x,
   input  logic signed [16:0] req_mom_y,
   input  logic signed [16:0] req_mom_z,
   input  logic               req_loose_btag,
   input  logic               req_last_of_event,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_event_passed,
   output logic [3:0]         rsp_failed_stage,
   output logic [34:0]        rsp_bb_mass_sq,
   output logic [34:0]        rsp_gg_mass_sq,
   output logic               rsp_store_overflow,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   cfg_type  cfg_ff;
   logic     q_push, q_pop, q_full, q_empty;
   item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jet_pt_min    <= 16'd480;
         cfg_ff.photon_pt_min <= 16'd480;
         cfg_ff.lepton_pt_min <= 16'd320;
         cfg_ff.eta_max       <= 13'd2458;
         cfg_ff.bb_mass_low   <= 16'd1760;
         cfg_ff.bb_mass_high  <= 16'd2400;
         cfg_ff.gg_mass_low   <= 16'd1920;
         cfg_ff.gg_mass_high  <= 16'd2080;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_JET_PT_MIN:    cfg_ff.jet_pt_min    <= csr_data;
            CSR_PHOTON_PT_MIN: cfg_ff.photon_pt_min <= csr_data;
            CSR_LEPTON_PT_MIN: cfg_ff.lepton_pt_min <= csr_data;
            CSR_ETA_MAX:       cfg_ff.eta_max       <= csr_data[12:0];
            CSR_BB_MASS_LOW:   cfg_ff.bb_mass_low   <= csr_data;
            CSR_BB_MASS_HIGH:  cfg_ff.bb_mass_high  <= csr_data;
            CSR_GG_MASS_LOW:   cfg_ff.gg_mass_low   <= csr_data;
            CSR_GG_MASS_HIGH:  cfg_ff.gg_mass_high  <= csr_data;
            default:           cfg_ff.jet_pt_min    <= cfg_ff.jet_pt_min;
         endcase
      end
   end

   assign req_full = q_full;

   dbs_front u_front (
      .req_push(req_push), .req_command(req_command),
      .req_trans_momentum(req_trans_momentum), .req_pseudorapidity(req_pseudorapidity),
      .req_azimuth(req_azimuth), .req_energy(req_energy), .req_mom_x(req_mom_x),
      .req_mom_y(req_mom_y), .req_mom_z(req_mom_z), .req_loose_btag(req_loose_btag),
      .req_last_of_event(req_last_of_event), .cfg(cfg_ff), .q_full(q_full),
      .q_push(q_push), .q_item(push_item)
   );

   dbs_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_item(push_item), .full(q_full),
      .pop(q_pop), .pop_item(pop_item), .empty(q_empty)
   );

   dbs_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_empty(q_empty), .q_item(pop_item),
      .q_pop(q_pop), .rsp_pop(rsp_pop), .rsp_empty(rsp_empty),
      .rsp_event_passed(rsp_event_passed), .rsp_failed_stage(rsp_failed_stage),
      .rsp_bb_mass_sq(rsp_bb_mass_sq), .rsp_gg_mass_sq(rsp_gg_mass_sq),
      .rsp_store_overflow(rsp_store_overflow)
   );

endmodule

@@ design/dbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dbs_front.sv @@
// Front end: preselects and classifies each incoming object transaction.
module dbs_front import dbs_pkg::*; (
   input  logic               req_push,
   input  logic [2:0]         req_command,
   input  logic [15:0]        req_trans_momentum,
   input  logic signed [13:0] req_pseudorapidity,
   input  logic signed [12:0] req_azimuth,
   input  logic [15:0]        req_energy,
   input  logic signed [16:0] req_mom_x,
   input  logic signed [16:0] req_mom_y,
   input  logic signed [16:0] req_mom_z,
   input  logic               req_loose_btag,
   input  logic               req_last_of_event,
   input  cfg_type            cfg,
   input  logic               q_full,
   output logic               q_push,
   output item_type           q_item
);

   logic [13:0] abs_eta;
   logic        eta_le;
   logic        eta_lt;

   always_comb begin
      abs_eta = req_pseudorapidity[13] ? 14'(-req_pseudorapidity) : 14'(req_pseudorapidity);
      eta_le  = abs_eta <= {1'b0, cfg.eta_max};
      eta_lt  = abs_eta <  {1'b0, cfg.eta_max};

      q_item.store      = 1'b0;
      q_item.lepton     = 1'b0;
      q_item.last       = req_last_of_event;
      q_item.obj.energy = req_energy;
      q_item.obj.mom_x  = req_mom_x;
      q_item.obj.mom_y  = req_mom_y;
      q_item.obj.mom_z  = req_mom_z;
      q_item.obj.pt     = req_trans_momentum;
      q_item.obj.eta    = req_pseudorapidity;
      q_item.obj.phi    = req_azimuth;
      q_item.obj.kind   = KIND_JET;

      case (req_command)
         CMD_JET: begin
            q_item.store    = eta_le && (req_trans_momentum >= cfg.jet_pt_min);
            q_item.obj.kind = req_loose_btag ? KIND_BJET : KIND_JET;
         end
         CMD_MUON, CMD_ELECTRON: begin
            q_item.lepton = (req_trans_momentum > cfg.lepton_pt_min) && eta_lt;
         end
         CMD_PHOTON: begin
            q_item.store    = eta_le && (req_trans_momentum >= cfg.photon_pt_min);
            q_item.obj.kind = KIND_PHOTON;
         end
         default: begin
            q_item.store = 1'b0;
         end
      endcase
   end

   assign q_push = req_push && !q_full;

endmodule

@@ design/dbs_queue.sv @@
// Four-entry queue between the front end and the cut-chain back end.
module dbs_queue import dbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int DEPTH = 4;

   item_type   slot_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full     = fill_ff == 3'(DEPTH);
   assign empty    = fill_ff == 3'd0;
   assign pop_item = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      fill_in   = fill_ff + 3'(do_push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/dbs_pair_calc.sv @@
// Three-stage pipeline: pair mass squared and dR < 0.4 test for two objects.
module dbs_pair_calc import dbs_pkg::*; (
   input  logic        clock,
   input  obj_type     obj_a,
   input  obj_type     obj_b,
   output logic [34:0] mass_sq,
   output logic        close
);

   logic [16:0]        esum_ff;
   logic signed [17:0] xsum_ff, ysum_ff, zsum_ff;
   logic signed [14:0] de_ff;
   logic signed [13:0] dp_ff;
   logic [33:0]        e2_ff;
   logic [34:0]        x2_ff, y2_ff, z2_ff;
   logic [28:0]        de2_ff;
   logic [26:0]        dp2_ff;
   logic [34:0]        mass_ff;
   logic               close_ff;
   logic signed [37:0] diff;
   logic [29:0]        dr_sum;
   logic [34:0]        dr_scaled;

   always_comb begin
      diff = $signed({4'b0, e2_ff}) - $signed({3'b0, x2_ff}) - $signed({3'b0, y2_ff})
             - $signed({3'b0, z2_ff});
      dr_sum    = 30'(de2_ff) + 30'(dp2_ff);
      dr_scaled = (35'(dr_sum) << 4) + (35'(dr_sum) << 3) + 35'(dr_sum);
   end

   always_ff @(posedge clock) begin
      esum_ff  <= 17'(obj_a.energy) + 17'(obj_b.energy);
      xsum_ff  <= 18'(obj_a.mom_x) + 18'(obj_b.mom_x);
      ysum_ff  <= 18'(obj_a.mom_y) + 18'(obj_b.mom_y);
      zsum_ff  <= 18'(obj_a.mom_z) + 18'(obj_b.mom_z);
      de_ff    <= 15'(obj_a.eta) - 15'(obj_b.eta);
      dp_ff    <= 14'(obj_a.phi) - 14'(obj_b.phi);
      e2_ff    <= esum_ff * esum_ff;
      x2_ff    <= 35'(xsum_ff * xsum_ff);
      y2_ff    <= 35'(ysum_ff * ysum_ff);
      z2_ff    <= 35'(zsum_ff * zsum_ff);
      de2_ff   <= 29'(de_ff * de_ff);
      dp2_ff   <= 27'(dp_ff * dp_ff);
      mass_ff  <= diff[37] ? 35'd0 : diff[34:0];
      close_ff <= dr_scaled < DR_LIMIT;
   end

   assign mass_sq = mass_ff;
   assign close   = close_ff;

endmodule

@@ design/dbs_back.sv @@
// Back end: object store, leading-object scan, W veto pair scan and cut chain.
module dbs_back import dbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  item_type    q_item,
   output logic        q_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic        rsp_event_passed,
   output logic [3:0]  rsp_failed_stage,
   output logic [34:0] rsp_bb_mass_sq,
   output logic [34:0] rsp_gg_mass_sq,
   output logic        rsp_store_overflow
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_DAT, ST_W_RD, ST_W_DAT, ST_CALC, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      PH_W, PH_BB, PH_GG, PH_ISO0, PH_ISO1, PH_ISO2, PH_ISO3
   } phase_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0] nb_ff, nb_in, np_ff, np_in;
   logic             lepton_ff, lepton_in, ovf_ff, ovf_in;
   obj_type          b1_ff, b1_in, b2_ff, b2_in, g1_ff, g1_in, g2_ff, g2_in;
   obj_type          op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic [1:0]       wait_ff, wait_in;
   logic [34:0]      bbm_ff, bbm_in, ggm_ff, ggm_in;
   logic [3:0]       stage_ff, stage_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_passed_ff, rsp_passed_in;
   logic [3:0]       rsp_stage_ff, rsp_stage_in;
   logic [34:0]      rsp_bbm_ff, rsp_bbm_in, rsp_ggm_ff, rsp_ggm_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             wr_en;
   logic [IDX_W-1:0] addr_a, addr_b;
   logic [OBJ_W-1:0] rdata_a, rdata_b;
   obj_type          ent_a, ent_b;
   logic [34:0]      mass_sq;
   logic             close;
   logic [31:0]      bb_lo_sq, bb_hi_sq, gg_lo_sq, gg_hi_sq;
   logic             bb_out, gg_out;

   dbs_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_OBJECTS)) u_ram_a (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[IDX_W-1:0]), .wr_data(q_item.obj),
      .rd_addr(addr_a), .rd_data(rdata_a)
   );

   dbs_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_OBJECTS)) u_ram_b (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[IDX_W-1:0]), .wr_data(q_item.obj),
      .rd_addr(addr_b), .rd_data(rdata_b)
   );

   dbs_pair_calc u_calc (
      .clock(clock), .obj_a(op_a_ff), .obj_b(op_b_ff), .mass_sq(mass_sq), .close(close)
   );

   assign ent_a = obj_type'(rdata_a);
   assign ent_b = obj_type'(rdata_b);

   always_comb begin
      bb_lo_sq = cfg.bb_mass_low * cfg.bb_mass_low;
      bb_hi_sq = cfg.bb_mass_high * cfg.bb_mass_high;
      gg_lo_sq = cfg.gg_mass_low * cfg.gg_mass_low;
      gg_hi_sq = cfg.gg_mass_high * cfg.gg_mass_high;
      bb_out   = (mass_sq < 35'(bb_lo_sq)) || (mass_sq > 35'(bb_hi_sq));
      gg_out   = (mass_sq < 35'(gg_lo_sq)) || (mass_sq > 35'(gg_hi_sq));
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      nb_in         = nb_ff;
      np_in         = np_ff;
      lepton_in     = lepton_ff;
      ovf_in        = ovf_ff;
      b1_in         = b1_ff;
      b2_in         = b2_ff;
      g1_in         = g1_ff;
      g2_in         = g2_ff;
      op_a_in       = op_a_ff;
      op_b_in       = op_b_ff;
      wait_in       = (wait_ff == 2'd3) ? wait_ff : wait_ff + 2'd1;
      bbm_in        = bbm_ff;
      ggm_in        = ggm_ff;
      stage_in      = stage_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_passed_in = rsp_passed_ff;
      rsp_stage_in  = rsp_stage_ff;
      rsp_bbm_in    = rsp_bbm_ff;
      rsp_ggm_in    = rsp_ggm_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      addr_a        = k_ff[IDX_W-1:0];
      addr_b        = j_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_item.lepton) begin
                  lepton_in = 1'b1;
               end
               if (q_item.store) begin
                  if (count_ff < CNT_W'(MAX_OBJECTS)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (q_item.last) begin
                  k_in     = '0;
                  nb_in    = '0;
                  np_in    = '0;
                  bbm_in   = '0;
                  ggm_in   = '0;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (k_ff == count_ff) begin
               if (nb_ff < CNT_W'(2)) begin
                  stage_in = STAGE_BJETS;
                  state_in = ST_FINISH;
               end else begin
                  i_in     = '0;
                  j_in     = CNT_W'(1);
                  state_in = ST_W_RD;
               end
            end else begin
               state_in = ST_SCAN_DAT;
            end
         end
         ST_SCAN_DAT: begin
            if (ent_a.kind == KIND_BJET) begin
               nb_in = nb_ff + 1'b1;
               if (nb_ff == '0) begin
                  b1_in = ent_a;
               end else if (ent_a.pt > b1_ff.pt) begin
                  b1_in = ent_a;
                  b2_in = b1_ff;
               end else if (nb_ff == CNT_W'(1) || ent_a.pt > b2_ff.pt) begin
                  b2_in = ent_a;
               end
            end else if (ent_a.kind == KIND_PHOTON) begin
               np_in = np_ff + 1'b1;
               if (np_ff == '0) begin
                  g1_in = ent_a;
               end else if (ent_a.pt > g1_ff.pt) begin
                  g1_in = ent_a;
                  g2_in = g1_ff;
               end else if (np_ff == CNT_W'(1) || ent_a.pt > g2_ff.pt) begin
                  g2_in = ent_a;
               end
            end
            k_in     = k_ff + 1'b1;
            state_in = ST_SCAN_RD;
         end
         ST_W_RD: begin
            addr_a = i_ff[IDX_W-1:0];
            if (i_ff + 1'b1 >= count_ff) begin
               op_a_in  = b1_ff;
               op_b_in  = b2_ff;
               wait_in  = '0;
               phase_in = PH_BB;
               state_in = ST_CALC;
            end else if (j_ff >= count_ff) begin
               i_in = i_ff + 1'b1;
               j_in = i_ff + CNT_W'(2);
            end else begin
               state_in = ST_W_DAT;
            end
         end
         ST_W_DAT: begin
            if (ent_a.kind == KIND_JET && ent_b.kind == KIND_JET) begin
               op_a_in  = ent_a;
               op_b_in  = ent_b;
               wait_in  = '0;
               phase_in = PH_W;
               state_in = ST_CALC;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_W_RD;
            end
         end
         ST_CALC: begin
            if (wait_ff == 2'd3) begin
               wait_in = '0;
               case (phase_ff)
                  PH_W: begin
                     if (mass_sq > W_MASS_LO_SQ && mass_sq < W_MASS_HI_SQ) begin
                        stage_in = STAGE_W_VETO;
                        state_in = ST_FINISH;
                     end else begin
                        j_in     = j_ff + 1'b1;
                        state_in = ST_W_RD;
                     end
                  end
                  PH_BB: begin
                     if (close) begin
                        stage_in = STAGE_BB_DR;
                        state_in = ST_FINISH;
                     end else begin
                        bbm_in = mass_sq;
                        if (bb_out) begin
                           stage_in = STAGE_BB_MASS;
                           state_in = ST_FINISH;
                        end else if (lepton_ff) begin
                           stage_in = STAGE_LEPTON;
                           state_in = ST_FINISH;
                        end else if (np_ff < CNT_W'(2)) begin
                           stage_in = STAGE_PHOTONS;
                           state_in = ST_FINISH;
                        end else begin
                           op_a_in  = g1_ff;
                           op_b_in  = g2_ff;
                           phase_in = PH_GG;
                        end
                     end
                  end
                  PH_GG: begin
                     ggm_in = mass_sq;
                     if (gg_out) begin
                        stage_in = STAGE_GG_MASS;
                        state_in = ST_FINISH;
                     end else if (close) begin
                        stage_in = STAGE_GG_DR;
                        state_in = ST_FINISH;
                     end else begin
                        op_a_in  = g1_ff;
                        op_b_in  = b1_ff;
                        phase_in = PH_ISO0;
                     end
                  end
                  default: begin
                     if (close) begin
                        stage_in = STAGE_ISO;
                        state_in = ST_FINISH;
                     end else if (phase_ff == PH_ISO3) begin
                        stage_in = STAGE_PASS;
                        state_in = ST_FINISH;
                     end else begin
                        op_a_in  = (phase_ff == PH_ISO0) ? g1_ff : g2_ff;
                        op_b_in  = (phase_ff == PH_ISO1) ? b1_ff : b2_ff;
                        phase_in = (phase_ff == PH_ISO0) ? PH_ISO1 :
                                   (phase_ff == PH_ISO1) ? PH_ISO2 : PH_ISO3;
                     end
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_passed_in = stage_ff == STAGE_PASS;
               rsp_stage_in  = stage_ff;
               rsp_bbm_in    = bbm_ff;
               rsp_ggm_in    = ggm_ff;
               rsp_ovf_in    = ovf_ff;
               count_in      = '0;
               lepton_in     = 1'b0;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         lepton_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wait_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lepton_ff    <= lepton_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         wait_ff      <= wait_in;
      end
      phase_ff      <= phase_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      nb_ff         <= nb_in;
      np_ff         <= np_in;
      b1_ff         <= b1_in;
      b2_ff         <= b2_in;
      g1_ff         <= g1_in;
      g2_ff         <= g2_in;
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      bbm_ff        <= bbm_in;
      ggm_ff        <= ggm_in;
      stage_ff      <= stage_in;
      rsp_passed_ff <= rsp_passed_in;
      rsp_stage_ff  <= rsp_stage_in;
      rsp_bbm_ff    <= rsp_bbm_in;
      rsp_ggm_ff    <= rsp_ggm_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_empty          = !rsp_valid_ff;
   assign rsp_event_passed   = rsp_passed_ff;
   assign rsp_failed_stage   = rsp_stage_ff;
   assign rsp_bb_mass_sq     = rsp_bbm_ff;
   assign rsp_gg_mass_sq     = rsp_ggm_ff;
   assign rsp_store_overflow = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_OBJECTS))
      else $error("object count beyond store depth");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && !q_empty)
      else $error("queue popped outside idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result produced outside finish");

   a_event_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=> count_ff == '0 && !lepton_ff && !ovf_ff)
      else $error("event state not cleared");

endmodule
